### hw/rtl/acsi_pkg.sv
// shared constants, types and helper functions for the csi command interpreter
`default_nettype none
package acsi_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 128;

    // register reset values
    localparam logic [8:0]  COLS_RST = 9'd80;
    localparam logic [7:0]  ROWS_RST = 8'd25;
    localparam logic [23:0] FG_RST   = 24'haaaaaa;
    localparam logic [23:0] BG_RST   = 24'h000000;

    // register indexes
    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_FG   = 2'd2;
    localparam logic [1:0] CFG_BG   = 2'd3;

    // characters
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_LBR  = 8'h5b;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_R    = 8'h52;

    // command bytes
    localparam logic [7:0] CMD_UP    = 8'h41;
    localparam logic [7:0] CMD_DOWN  = 8'h42;
    localparam logic [7:0] CMD_RIGHT = 8'h43;
    localparam logic [7:0] CMD_LEFT  = 8'h44;
    localparam logic [7:0] CMD_NEXTL = 8'h45;
    localparam logic [7:0] CMD_PREVL = 8'h46;
    localparam logic [7:0] CMD_COL   = 8'h47;
    localparam logic [7:0] CMD_POS   = 8'h48;
    localparam logic [7:0] CMD_POSF  = 8'h66;
    localparam logic [7:0] CMD_ROW   = 8'h64;
    localparam logic [7:0] CMD_SGR   = 8'h6d;
    localparam logic [7:0] CMD_ED    = 8'h4a;
    localparam logic [7:0] CMD_EL    = 8'h4b;
    localparam logic [7:0] CMD_ECH   = 8'h58;
    localparam logic [7:0] CMD_DSR   = 8'h6e;
    localparam logic [7:0] CMD_SET   = 8'h68;
    localparam logic [7:0] CMD_RESET = 8'h6c;

    typedef struct packed {
        logic [1:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
        logic [1:0] len;
    } dec_t;

    // eight-colour palette
    function automatic logic [23:0] palette(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = 24'h000000;
            3'd1:    c = 24'haa0000;
            3'd2:    c = 24'h00aa00;
            3'd3:    c = 24'haa5500;
            3'd4:    c = 24'h0000aa;
            3'd5:    c = 24'haa00aa;
            3'd6:    c = 24'h00aaaa;
            default: c = 24'haaaaaa;
        endcase
        return c;
    endfunction

    // decimal digits of a value below 300 that fits 9 bits
    function automatic dec_t to_dec(input logic [8:0] v);
        dec_t        d;
        logic [8:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        d.d2 = (v >= 9'd200) ? 2'd2 : ((v >= 9'd100) ? 2'd1 : 2'd0);
        r    = v - 9'(d.d2 * 7'd100);
        prod = 15'(r[6:0] * 8'd205);
        t    = prod[14:11];
        d.d1 = t;
        d.d0 = 4'(r[6:0] - 7'(t * 4'd10));
        d.len = (v >= 9'd100) ? 2'd3 : ((v >= 9'd10) ? 2'd2 : 2'd1);
        return d;
    endfunction

    // digit k (most significant first) of a decoded value
    function automatic logic [7:0] dec_char(input dec_t d, input logic [1:0] k);
        logic [3:0] dg;
        logic [1:0] pos;
        pos = 2'(d.len - 2'd1 - k);
        case (pos)
            2'd2:    dg = {2'b00, d.d2};
            2'd1:    dg = d.d1;
            default: dg = d.d0;
        endcase
        return CH_0 + {4'd0, dg};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ansi_csi_command_interpreter.sv
// csi escape sequence interpreter: cursor, colours, erase ranges and position reports
// the status result appears in the cycle after the final byte's transaction
// throughput: one byte per cycle while not held; parameter bytes give no result
// a position report holds the input for its reply bytes (up to ten of them),
// sent through the single output register that carries one result at a time
// reset: asynchronous active low, clears cursor, parse state and output valid
`default_nettype none
module ansi_csi_command_interpreter
    import acsi_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  seq_byte,
    input  wire logic        final_req,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [7:0]       reply_byte,
    output logic [7:0]       cursor_col,
    output logic [6:0]       cursor_row,
    output logic [23:0]      fg_colour,
    output logic [23:0]      bg_colour,
    output logic             cursor_hidden,
    output logic             clear_valid,
    output logic [15:0]      clear_start,
    output logic [15:0]      clear_end,
    output logic             unknown_cmd,
    output logic             last
);

    localparam int COL_LIM = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int ROW_LIM = (MAX_ROWS < 128) ? MAX_ROWS : 128;

    // configuration registers
    logic [8:0]  cols_cfg_reg;
    logic [7:0]  rows_cfg_reg;
    logic [23:0] dfg_reg, dbg_reg;

    // terminal and parse state
    logic [7:0]  col_reg, col_next;
    logic [6:0]  row_reg, row_next;
    logic [23:0] fg_reg, fg_next, bg_reg, bg_next;
    logic        hide_reg, hide_next;
    logic [15:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  bidx_reg, bidx_next;
    logic [7:0]  third_reg, third_next;

    // reply sequencer
    logic        rep_active_reg;
    logic [3:0]  rep_idx_reg;
    logic [7:0]  rep_row_reg;
    logic [8:0]  rep_col_reg;

    // output register
    logic        ov_reg;
    logic        rk_reg, hid_o_reg, cv_reg, unk_reg, last_reg;
    logic [7:0]  rb_reg, col_o_reg;
    logic [6:0]  row_o_reg;
    logic [23:0] fg_o_reg, bg_o_reg;
    logic [15:0] cs_reg, ce_reg;

    logic advance, in_fire, fin_fire, rep_load;

    assign advance  = !ov_reg || out_ready;
    assign in_ready = advance && !rep_active_reg;
    assign in_fire  = in_valid && in_ready;
    assign fin_fire = in_fire && final_req;
    assign rep_load = advance && rep_active_reg;

    // effective screen size
    logic [8:0] cols;
    logic [7:0] rows;
    always_comb
    begin
        if (cols_cfg_reg == 9'd0)
            cols = 9'd1;
        else if (cols_cfg_reg > 9'(COL_LIM))
            cols = 9'(COL_LIM);
        else
            cols = cols_cfg_reg;
        if (rows_cfg_reg == 8'd0)
            rows = 8'd1;
        else if (rows_cfg_reg > 8'(ROW_LIM))
            rows = 8'(ROW_LIM);
        else
            rows = rows_cfg_reg;
    end

    // cursor clamped into the screen, counts and linear addresses
    logic [7:0]  cp, cmax;
    logic [6:0]  rp, rmax;
    logic [15:0] a, p, sp;
    logic [16:0] row_up, col_up, x_end;
    logic [15:0] base, total;
    logic [7:0]  third_eff;

    always_comb
    begin
        cmax  = 8'(cols - 9'd1);
        rmax  = 7'(rows - 8'd1);
        cp    = ({1'b0, col_reg} >= cols) ? cmax : col_reg;
        rp    = ({1'b0, row_reg} >= rows) ? rmax : row_reg;
        p     = p1_reg;
        a     = (p1_reg == 16'd0) ? 16'd1 : p1_reg;
        sp    = (p2_reg == 16'd0) ? 16'd1 : p2_reg;
        row_up = {10'd0, rp} + {1'b0, a};
        col_up = {9'd0, cp} + {1'b0, a};
        x_end  = (col_up > {8'd0, cols}) ? {8'd0, cols} : col_up;
        base  = 16'(rp * cols);
        total = 16'(cols * rows);
        third_eff = (bidx_reg == 3'd2) ? seq_byte : third_reg;
    end

    // command decode
    logic        cv, unk, dsr;
    logic [15:0] cs, ce;
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        hide_next = hide_reg;
        cv  = 1'b0;
        unk = 1'b0;
        dsr = 1'b0;
        cs  = 16'd0;
        ce  = 16'd0;
        if (fin_fire)
        begin
            col_next = cp;
            row_next = rp;
            if (kind)
            begin
                if (seq_byte == CMD_SET || seq_byte == CMD_RESET)
                begin
                    if (a == 16'd25)
                        hide_next = (seq_byte == CMD_RESET);
                    else if (a != 16'd12 && a != 16'd2004)
                        unk = 1'b1;
                end
                else
                    unk = 1'b1;
            end
            else
            begin
                unique case (seq_byte)
                    CMD_SGR:
                    begin
                        if (p == 16'd0)
                        begin
                            fg_next = dfg_reg;
                            bg_next = dbg_reg;
                        end
                        else if (p == 16'd1 || p == 16'd10)
                            unk = 1'b0;
                        else if (p == 16'd7)
                        begin
                            fg_next = bg_reg;
                            bg_next = fg_reg;
                        end
                        else if (p >= 16'd30 && p <= 16'd37)
                            fg_next = palette(3'(p - 16'd30));
                        else if (p == 16'd39)
                            fg_next = dfg_reg;
                        else if (p >= 16'd40 && p <= 16'd47)
                            bg_next = palette(3'(p - 16'd40));
                        else if (p == 16'd49)
                            bg_next = dbg_reg;
                        else
                            unk = 1'b1;
                    end
                    CMD_UP:
                        row_next = ({9'd0, rp} <= a) ? 7'd0 : 7'({9'd0, rp} - a);
                    CMD_DOWN:
                        row_next = (row_up > {10'd0, rmax}) ? rmax : 7'(row_up);
                    CMD_RIGHT:
                        col_next = (col_up > {9'd0, cmax}) ? cmax : 8'(col_up);
                    CMD_LEFT:
                        col_next = ({8'd0, cp} <= a) ? 8'd0 : 8'({8'd0, cp} - a);
                    CMD_NEXTL:
                    begin
                        col_next = 8'd0;
                        row_next = (row_up > {10'd0, rmax}) ? rmax : 7'(row_up);
                    end
                    CMD_PREVL:
                    begin
                        col_next = 8'd0;
                        row_next = ({9'd0, rp} <= a) ? 7'd0 : 7'({9'd0, rp} - a);
                    end
                    CMD_COL:
                        col_next = (a < {7'd0, cols}) ? 8'(a - 16'd1) : cmax;
                    CMD_ROW:
                        row_next = (a < {8'd0, rows}) ? 7'(a - 16'd1) : rmax;
                    CMD_POS, CMD_POSF:
                    begin
                        row_next = (a < {8'd0, rows}) ? 7'(a - 16'd1) : rmax;
                        col_next = (sp < {7'd0, cols}) ? 8'(sp - 16'd1) : cmax;
                    end
                    CMD_ED:
                    begin
                        cv = 1'b1;
                        if (third_eff == CH_1)
                            ce = base + {8'd0, cp} + 16'd1;
                        else if (third_eff == CH_2)
                            ce = total;
                        else
                        begin
                            cs = base + {8'd0, cp};
                            ce = total;
                        end
                    end
                    CMD_EL:
                    begin
                        cv = 1'b1;
                        cs = (third_eff == CH_1 || third_eff == CH_2) ? base
                                                                     : base + {8'd0, cp};
                        ce = (third_eff == CH_1) ? base + {8'd0, cp} + 16'd1
                                                 : base + {7'd0, cols};
                    end
                    CMD_ECH:
                    begin
                        cv = 1'b1;
                        cs = base + {8'd0, cp};
                        ce = base + 16'(x_end);
                    end
                    CMD_DSR:
                    begin
                        if (p == 16'd6)
                            dsr = 1'b1;
                        else
                            unk = 1'b1;
                    end
                    default:
                        unk = 1'b1;
                endcase
            end
        end
    end

    // parameter parsing
    logic [3:0]  digit;
    logic [19:0] acc1, acc2;
    logic [1:0]  start;
    always_comb
    begin
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        phase_next = phase_reg;
        bidx_next  = bidx_reg;
        third_next = third_reg;
        digit = 4'(seq_byte - CH_0);
        acc1  = {p1_reg, 3'b000} + {3'b000, p1_reg, 1'b0} + {16'd0, digit};
        acc2  = {p2_reg, 3'b000} + {3'b000, p2_reg, 1'b0} + {16'd0, digit};
        start = kind ? 2'd3 : 2'd2;
        if (in_fire)
        begin
            if (final_req)
            begin
                p1_next    = 16'd0;
                p2_next    = 16'd0;
                phase_next = 2'd0;
                bidx_next  = 3'd0;
                third_next = 8'd0;
            end
            else
            begin
                if (bidx_reg == 3'd2)
                    third_next = seq_byte;
                if (bidx_reg >= {1'b0, start} && phase_reg < 2'd2)
                begin
                    if (seq_byte >= CH_0 && seq_byte <= CH_9)
                    begin
                        if (phase_reg == 2'd0)
                            p1_next = (acc1 > 20'd65535) ? 16'hffff : 16'(acc1);
                        else
                            p2_next = (acc2 > 20'd65535) ? 16'hffff : 16'(acc2);
                    end
                    else if (phase_reg == 2'd0 && seq_byte == CH_SEMI)
                        phase_next = 2'd1;
                    else
                        phase_next = 2'd2;
                end
                if (bidx_reg < 3'd7)
                    bidx_next = bidx_reg + 3'd1;
            end
        end
    end

    // reply byte selection
    dec_t       rdec, cdec;
    logic [3:0] rep_len, k;
    logic [7:0] rep_char;
    always_comb
    begin
        rdec    = to_dec({1'b0, rep_row_reg});
        cdec    = to_dec(rep_col_reg);
        rep_len = 4'd4 + {2'd0, rdec.len} + {2'd0, cdec.len};
        k       = rep_idx_reg;
        if (k == 4'd0)
            rep_char = CH_ESC;
        else if (k == 4'd1)
            rep_char = CH_LBR;
        else if (k < 4'd2 + {2'd0, rdec.len})
            rep_char = dec_char(rdec, 2'(k - 4'd2));
        else if (k == 4'd2 + {2'd0, rdec.len})
            rep_char = CH_SEMI;
        else if (k < 4'd3 + {2'd0, rdec.len} + {2'd0, cdec.len})
            rep_char = dec_char(cdec, 2'(k - 4'd3 - {2'd0, rdec.len}));
        else
            rep_char = CH_R;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= COLS_RST;
            rows_cfg_reg <= ROWS_RST;
            dfg_reg      <= FG_RST;
            dbg_reg      <= BG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLS: cols_cfg_reg <= cfg_data[8:0];
                CFG_ROWS: rows_cfg_reg <= cfg_data[7:0];
                CFG_FG:   dfg_reg      <= cfg_data;
                CFG_BG:   dbg_reg      <= cfg_data;
                default:  dbg_reg      <= dbg_reg;
            endcase
        end
    end

    // terminal, parse and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= 8'd0;
            row_reg        <= 7'd0;
            fg_reg         <= FG_RST;
            bg_reg         <= BG_RST;
            hide_reg       <= 1'b0;
            p1_reg         <= 16'd0;
            p2_reg         <= 16'd0;
            phase_reg      <= 2'd0;
            bidx_reg       <= 3'd0;
            third_reg      <= 8'd0;
            rep_active_reg <= 1'b0;
            rep_idx_reg    <= 4'd0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            hide_reg  <= hide_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            phase_reg <= phase_next;
            bidx_reg  <= bidx_next;
            third_reg <= third_next;
            if (fin_fire && dsr)
            begin
                rep_active_reg <= 1'b1;
                rep_idx_reg    <= 4'd0;
            end
            else if (rep_load)
            begin
                rep_idx_reg <= rep_idx_reg + 4'd1;
                if (rep_idx_reg == rep_len - 4'd1)
                    rep_active_reg <= 1'b0;
            end
            if (fin_fire || rep_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            rk_reg      <= 1'b0;
            rb_reg      <= 8'd0;
            col_o_reg   <= col_next;
            row_o_reg   <= row_next;
            fg_o_reg    <= fg_next;
            bg_o_reg    <= bg_next;
            hid_o_reg   <= hide_next;
            cv_reg      <= cv;
            cs_reg      <= cs;
            ce_reg      <= ce;
            unk_reg     <= unk;
            last_reg    <= !dsr;
            rep_row_reg <= {1'b0, row_next} + 8'd1;
            rep_col_reg <= {1'b0, col_next} + 9'd1;
        end
        else if (rep_load)
        begin
            rk_reg    <= 1'b1;
            rb_reg    <= rep_char;
            col_o_reg <= col_reg;
            row_o_reg <= row_reg;
            fg_o_reg  <= fg_reg;
            bg_o_reg  <= bg_reg;
            hid_o_reg <= hide_reg;
            cv_reg    <= 1'b0;
            cs_reg    <= 16'd0;
            ce_reg    <= 16'd0;
            unk_reg   <= 1'b0;
            last_reg  <= (rep_idx_reg == rep_len - 4'd1);
        end
    end

    assign out_valid     = ov_reg;
    assign result_kind   = rk_reg;
    assign reply_byte    = rb_reg;
    assign cursor_col    = col_o_reg;
    assign cursor_row    = row_o_reg;
    assign fg_colour     = fg_o_reg;
    assign bg_colour     = bg_o_reg;
    assign cursor_hidden = hid_o_reg;
    assign clear_valid   = cv_reg;
    assign clear_start   = cs_reg;
    assign clear_end     = ce_reg;
    assign unknown_cmd   = unk_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

### hw/rtl/acsi_checker.sv
// port-level checks for the csi command interpreter, bound to the top level
`default_nettype none
module acsi_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic result_kind,
    input wire logic clear_valid,
    input wire logic unknown_cmd,
    input wire logic last
);

    // a result waiting on the output stays there
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // reply bytes never carry a fill range or error flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> !clear_valid && !unknown_cmd)
        else $error("reply byte carries status flags");

    // input is held while a report burst is unfinished
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken during a report burst");

    // a taken non-final result is followed at once by a reply byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && result_kind)
        else $error("report burst broken");

endmodule

bind ansi_csi_command_interpreter acsi_checker u_acsi_checker (.*);
`default_nettype wire

### bench/tb.sv
// testbench for the csi command interpreter: scoreboard class, stimulus and result checking
`timescale 1ns / 1ps
module tb;
    import acsi_pkg::*;

    // bytes used only by the stimulus
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CMD_INSL = 8'h4c;
    localparam logic [7:0] CMD_ICH  = 8'h40;
    localparam logic [7:0] CMD_DCH  = 8'h50;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  reply_byte;
        logic [7:0]  cursor_col;
        logic [6:0]  cursor_row;
        logic [23:0] fg_colour;
        logic [23:0] bg_colour;
        logic        cursor_hidden;
        logic        clear_valid;
        logic [15:0] clear_start;
        logic [15:0] clear_end;
        logic        unknown_cmd;
        logic        last;
    } term_status_t;

    // terminal predictor with its own copy of state and registers
    class term_scoreboard;
        int unsigned cols_reg, rows_reg, fg_def, bg_def;
        int unsigned cur_col, cur_row, fg_cur, bg_cur, hidden;
        int unsigned arg0, arg1, arg_phase, byte_pos, third_ch;
        term_status_t pending_status[$];
        int errors;
        int finals;
        int reports;

        function new();
            cols_reg = COLS_RST; rows_reg = ROWS_RST;
            fg_def = FG_RST; bg_def = BG_RST;
            cur_col = 0; cur_row = 0; fg_cur = FG_RST; bg_cur = BG_RST; hidden = 0;
            errors = 0; finals = 0; reports = 0;
            restart_parse();
        endfunction

        function void restart_parse();
            arg0 = 0; arg1 = 0; arg_phase = 0; byte_pos = 0; third_ch = 0;
        endfunction

        function void write_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                CFG_COLS: cols_reg = val & 'h1ff;
                CFG_ROWS: rows_reg = val & 'hff;
                CFG_FG:   fg_def = val & 'hffffff;
                default:  bg_def = val & 'hffffff;
            endcase
        endfunction

        function int unsigned colour_of(int unsigned i);
            case (i & 7)
                0: return 'h000000;
                1: return 'haa0000;
                2: return 'h00aa00;
                3: return 'haa5500;
                4: return 'h0000aa;
                5: return 'haa00aa;
                6: return 'h00aaaa;
                default: return 'haaaaaa;
            endcase
        endfunction

        function term_status_t make_status(bit rk, int unsigned rb, bit cv,
                int unsigned cs, int unsigned ce, bit unk, bit lst);
            term_status_t s;
            s.result_kind = rk; s.reply_byte = rb[7:0];
            s.cursor_col = cur_col[7:0]; s.cursor_row = cur_row[6:0];
            s.fg_colour = fg_cur[23:0]; s.bg_colour = bg_cur[23:0];
            s.cursor_hidden = hidden[0]; s.clear_valid = cv;
            s.clear_start = cs[15:0]; s.clear_end = ce[15:0];
            s.unknown_cmd = unk; s.last = lst;
            return s;
        endfunction

        function void push_decimal(ref byte unsigned rep[$], input int unsigned v);
            string s;
            s.itoa(v);
            foreach (s[i]) rep.push_back(s[i]);
        endfunction

        function int unsigned sat_acc(int unsigned v, int unsigned d);
            v = v * 10 + d;
            return v > 65535 ? 65535 : v;
        endfunction

        // note one accepted input transaction
        function void note_byte(bit knd, logic [7:0] b, bit fin);
            int unsigned first_arg_pos, cols, rows, p, a, base, t, cs, ce;
            bit cv, unk;
            byte unsigned rep[$];
            first_arg_pos = knd ? 3 : 2;
            if (byte_pos == 2) third_ch = b;
            if (!fin) begin
                if (byte_pos >= first_arg_pos && arg_phase < 2) begin
                    if (b >= CH_0 && b <= CH_9) begin
                        if (arg_phase == 0) arg0 = sat_acc(arg0, b - CH_0);
                        else arg1 = sat_acc(arg1, b - CH_0);
                    end
                    else if (arg_phase == 0 && b == CH_SEMI) arg_phase = 1;
                    else arg_phase = 2;
                end
                if (byte_pos < 7) byte_pos++;
                return;
            end
            finals++;
            cols = cols_reg < 1 ? 1 : (cols_reg > 256 ? 256 : cols_reg);
            rows = rows_reg < 1 ? 1 : (rows_reg > 128 ? 128 : rows_reg);
            if (cur_col >= cols) cur_col = cols - 1;
            if (cur_row >= rows) cur_row = rows - 1;
            p = arg0; a = p ? p : 1; base = cur_row * cols;
            cv = 0; cs = 0; ce = 0; unk = 0;
            if (knd) begin
                if (b == CMD_SET || b == CMD_RESET) begin
                    if (a == 25) hidden = (b == CMD_RESET);
                    else if (a != 12 && a != 2004) unk = 1;
                end
                else unk = 1;
            end
            else begin
                case (b)
                    CMD_SGR: begin
                        if (p == 0) begin fg_cur = fg_def; bg_cur = bg_def; end
                        else if (p == 1 || p == 10) ;
                        else if (p == 7) begin t = fg_cur; fg_cur = bg_cur; bg_cur = t; end
                        else if (p >= 30 && p <= 37) fg_cur = colour_of(p - 30);
                        else if (p == 39) fg_cur = fg_def;
                        else if (p >= 40 && p <= 47) bg_cur = colour_of(p - 40);
                        else if (p == 49) bg_cur = bg_def;
                        else unk = 1;
                    end
                    CMD_UP:    cur_row = cur_row <= a ? 0 : cur_row - a;
                    CMD_DOWN:  cur_row = cur_row + a > rows - 1 ? rows - 1 : cur_row + a;
                    CMD_RIGHT: cur_col = cur_col + a > cols - 1 ? cols - 1 : cur_col + a;
                    CMD_LEFT:  cur_col = cur_col <= a ? 0 : cur_col - a;
                    CMD_NEXTL: begin
                        cur_col = 0;
                        cur_row = cur_row + a > rows - 1 ? rows - 1 : cur_row + a;
                    end
                    CMD_PREVL: begin
                        cur_col = 0;
                        cur_row = cur_row <= a ? 0 : cur_row - a;
                    end
                    CMD_COL: cur_col = a < cols ? a - 1 : cols - 1;
                    CMD_ROW: cur_row = a < rows ? a - 1 : rows - 1;
                    CMD_POS, CMD_POSF: begin
                        t = arg1 ? arg1 : 1;
                        cur_row = a < rows ? a - 1 : rows - 1;
                        cur_col = t < cols ? t - 1 : cols - 1;
                    end
                    CMD_ED: begin
                        cv = 1;
                        if (third_ch == CH_1) begin cs = 0; ce = base + cur_col + 1; end
                        else if (third_ch == CH_2) begin cs = 0; ce = cols * rows; end
                        else begin cs = base + cur_col; ce = cols * rows; end
                    end
                    CMD_EL: begin
                        cv = 1;
                        if (third_ch == CH_1) begin cs = base; ce = base + cur_col + 1; end
                        else if (third_ch == CH_2) begin cs = base; ce = base + cols; end
                        else begin cs = base + cur_col; ce = base + cols; end
                    end
                    CMD_ECH: begin
                        cv = 1;
                        cs = base + cur_col;
                        ce = base + (cur_col + a > cols ? cols : cur_col + a);
                    end
                    CMD_DSR: begin
                        if (p == 6) begin
                            rep.push_back(CH_ESC);
                            rep.push_back(CH_LBR);
                            push_decimal(rep, cur_row + 1);
                            rep.push_back(CH_SEMI);
                            push_decimal(rep, cur_col + 1);
                            rep.push_back(CH_R);
                            reports++;
                        end
                        else unk = 1;
                    end
                    default: unk = 1;
                endcase
            end
            pending_status.push_back(make_status(0, 0, cv, cs, ce, unk, rep.size() == 0));
            foreach (rep[i])
                pending_status.push_back(make_status(1, rep[i], 0, 0, 0, 0,
                    i == rep.size() - 1));
            restart_parse();
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
            errors++;
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(term_status_t got);
            term_status_t want;
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (got.result_kind !== want.result_kind)
                report_field("result_kind", want.result_kind, got.result_kind);
            if (got.reply_byte !== want.reply_byte)
                report_field("reply_byte", want.reply_byte, got.reply_byte);
            if (got.cursor_col !== want.cursor_col)
                report_field("cursor_col", want.cursor_col, got.cursor_col);
            if (got.cursor_row !== want.cursor_row)
                report_field("cursor_row", want.cursor_row, got.cursor_row);
            if (got.fg_colour !== want.fg_colour)
                report_field("fg_colour", want.fg_colour, got.fg_colour);
            if (got.bg_colour !== want.bg_colour)
                report_field("bg_colour", want.bg_colour, got.bg_colour);
            if (got.cursor_hidden !== want.cursor_hidden)
                report_field("cursor_hidden", want.cursor_hidden, got.cursor_hidden);
            if (got.clear_valid !== want.clear_valid)
                report_field("clear_valid", want.clear_valid, got.clear_valid);
            if (got.clear_start !== want.clear_start)
                report_field("clear_start", want.clear_start, got.clear_start);
            if (got.clear_end !== want.clear_end)
                report_field("clear_end", want.clear_end, got.clear_end);
            if (got.unknown_cmd !== want.unknown_cmd)
                report_field("unknown_cmd", want.unknown_cmd, got.unknown_cmd);
            if (got.last !== want.last)
                report_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  seq_byte;
    logic        final_req;
    logic        out_valid;
    logic        out_ready;
    term_status_t got_status;

    term_scoreboard board;
    bit hold_off;
    int bytes_sent;

    ansi_csi_command_interpreter dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .seq_byte(seq_byte), .final_req(final_req),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(got_status.result_kind), .reply_byte(got_status.reply_byte),
        .cursor_col(got_status.cursor_col), .cursor_row(got_status.cursor_row),
        .fg_colour(got_status.fg_colour), .bg_colour(got_status.bg_colour),
        .cursor_hidden(got_status.cursor_hidden), .clear_valid(got_status.clear_valid),
        .clear_start(got_status.clear_start), .clear_end(got_status.clear_end),
        .unknown_cmd(got_status.unknown_cmd), .last(got_status.last)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver side: checks each taken result; random stalls, one long hold-off on request
    initial
    begin
        int g;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) board.check_result(got_status);
            if (hold_off) begin
                out_ready <= 0;
                repeat (60) @(posedge clk);
                hold_off = 0;
                out_ready <= 1;
            end
            else if (bytes_sent > 140 && bytes_sent < 190) out_ready <= 1;
            else begin
                g = $urandom_range(0, 99);
                out_ready <= (g < 65) ? 1'b1 : (g < 97 ? 1'b0 : 1'b0);
            end
        end
    end

    // offer one byte and wait for its transaction
    task automatic send_byte(bit knd, logic [7:0] b, bit fin);
        int g;
        g = gap_len();
        if (bytes_sent > 100 && bytes_sent < 130) g = 0;
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1; kind <= knd; seq_byte <= b; final_req <= fin;
        do @(posedge clk); while (!in_ready);
        board.note_byte(knd, b, fin);
        bytes_sent++;
    endtask

    // one whole sequence: ESC '[' optional '?', text, final byte
    task automatic send_seq(bit knd, string body, logic [7:0] fin_ch);
        send_byte(knd, CH_ESC, 0);
        send_byte(knd, CH_LBR, 0);
        if (knd) send_byte(knd, CH_QMARK, 0);
        foreach (body[i]) send_byte(knd, body[i], 0);
        send_byte(knd, fin_ch, 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.pending_status.size() != 0) @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic string rand_num();
        string s;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return "";
        if (r == 1) return "70000";
        if (r < 5) s.itoa($urandom_range(0, 9));
        else s.itoa($urandom_range(0, 300));
        return s;
    endfunction

    function automatic logic [7:0] rand_cmd();
        logic [7:0] cmds[18] = '{CMD_UP, CMD_DOWN, CMD_RIGHT, CMD_LEFT, CMD_NEXTL,
            CMD_PREVL, CMD_COL, CMD_POS, CMD_POSF, CMD_ROW, CMD_SGR, CMD_ED, CMD_EL,
            CMD_ECH, CMD_DSR, CMD_INSL, CMD_ICH, CMD_DCH};
        return cmds[$urandom_range(0, 17)];
    endfunction

    task automatic random_phase(int n);
        int r;
        string body;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                body = rand_num();
                if ($urandom_range(0, 2) == 0) body = {body, ";", rand_num()};
                send_seq(0, body, rand_cmd());
            end
            else if (r < 68) send_seq(0, {"3", rand_num()}, CMD_SGR);
            else if (r < 74) send_seq(0, "6", CMD_DSR);
            else if (r < 82) begin
                body.itoa(($urandom_range(0, 2) == 0) ? 25 : $urandom_range(0, 3000));
                send_seq(1, body, ($urandom_range(0, 3) == 0) ? rand_cmd() :
                    ($urandom_range(0, 1) ? CMD_SET : CMD_RESET));
            end
            else begin
                // noise: raw bytes, early finals, broken parameters
                repeat ($urandom_range(1, 6))
                    send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0);
                send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1);
            end
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 0; cfg_we = 0; cfg_index = CFG_COLS; cfg_data = 0;
        in_valid = 0; kind = 0; seq_byte = 0; final_req = 0;
        hold_off = 0; bytes_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every command, extremes and special cases
        send_seq(0, "", CMD_DSR);
        send_seq(0, "6", CMD_DSR);
        send_seq(0, "128;256", CMD_POS);
        send_seq(0, "6", CMD_DSR);
        send_seq(0, "99999", CMD_UP);
        send_seq(0, "0", CMD_DOWN);
        send_seq(0, "3", CMD_RIGHT);
        send_seq(0, "", CMD_LEFT);
        send_seq(0, "2", CMD_NEXTL);
        send_seq(0, "1", CMD_PREVL);
        send_seq(0, "40", CMD_COL);
        send_seq(0, "7", CMD_ROW);
        send_seq(0, "5;9", CMD_POSF);
        send_seq(0, "1", CMD_ED);
        send_seq(0, "2", CMD_EL);
        send_seq(0, "", CMD_ECH);
        send_seq(0, "300", CMD_ECH);
        send_seq(0, "31", CMD_SGR);
        send_seq(0, "47", CMD_SGR);
        send_seq(0, "7", CMD_SGR);
        send_seq(0, "38", CMD_SGR);
        send_seq(1, "25", CMD_RESET);
        send_seq(1, "2004", CMD_SET);
        send_seq(1, "7", CMD_SET);
        send_seq(0, "5", CMD_INSL);
        send_byte(0, CH_ESC, 1);
        drain();

        // smallest screen, odd colour defaults
        write_cfg(CFG_COLS, 0);
        write_cfg(CFG_ROWS, 0);
        write_cfg(CFG_FG, 24'hffffff);
        write_cfg(CFG_BG, 24'h123456);
        random_phase(5);
        drain();

        // oversized registers clamp to the largest screen; receiver holds off
        write_cfg(CFG_COLS, 24'h1ff);
        write_cfg(CFG_ROWS, 24'hff);
        write_cfg(CFG_BG, 0);
        hold_off = 1;
        random_phase(6);
        drain();

        // shrunk screen with the cursor left outside it
        write_cfg(CFG_COLS, 7);
        write_cfg(CFG_ROWS, 3);
        random_phase(4);
        drain();
        write_cfg(CFG_COLS, 256);
        write_cfg(CFG_ROWS, 128);
        write_cfg(CFG_FG, 24'h5a5a5a);
        random_phase(4);
        drain();

        $display("covered %0d bytes, %0d commands, %0d position reports",
            bytes_sent, board.finals, board.reports);
        $display("screen sizes from 1x1 to the clamped maximum, with long output stalls");
        if (board.errors == 0 && board.pending_status.size() == 0)
            $display("ansi_csi_command_interpreter verification clean");
        else
            $display("ansi_csi_command_interpreter verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("ansi_csi_command_interpreter verification failed");
        $finish;
    end
endmodule

### sim.f
hw/rtl/acsi_pkg.sv
hw/rtl/ansi_csi_command_interpreter.sv
hw/rtl/acsi_checker.sv
bench/tb.sv
